// ===== hw/rtl/cobsdec_pkg.sv =====
// cobsdec_pkg: shared constants and the result record of the cobs stream frame decoder
// no dependencies; used by cobsdec_core, cobsdec_out_stage and cobs_stream_frame_decoder
`default_nettype none

package cobsdec_pkg;

   localparam int ByteWidth     = 8;
   localparam int FrameLenWidth = 16;

   // frame byte counter saturates here
   localparam int MaxFrameCount = 65535;
   localparam int CountWidth    = $clog2(MaxFrameCount + 1);

   // code byte that announces a run with no stuffed delimiter after it
   localparam logic [ByteWidth-1:0] LongCode = 8'hFF;

   typedef struct packed {
      logic                     data_valid;
      logic [ByteWidth-1:0]     data_byte;
      logic                     frame_done;
      logic [FrameLenWidth-1:0] frame_length;
      logic                     hunting;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cobsdec_core.sv =====
// cobsdec_core: decode state machine, one encoded byte per accepted transaction
// depends on cobsdec_pkg
`default_nettype none

module cobsdec_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 byte_accept,
   input  wire logic [cobsdec_pkg::ByteWidth-1:0]    in_byte,
   input  wire logic [cobsdec_pkg::ByteWidth-1:0]    delimiter,
   output cobsdec_pkg::result_type                   result
);

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_CODE,
      PHASE_RUN,
      PHASE_STUFF
   } phase_type;

   localparam logic [cobsdec_pkg::CountWidth-1:0] CountMax =
      cobsdec_pkg::CountWidth'(cobsdec_pkg::MaxFrameCount);
   localparam logic [cobsdec_pkg::FrameLenWidth-1:0] LenMax = '1;

   phase_type                                 phase_ff, phase_in;
   logic [cobsdec_pkg::ByteWidth-1:0]         run_left_ff, run_left_in;
   logic                                      long_run_ff, long_run_in;
   logic [cobsdec_pkg::CountWidth-1:0]        count_ff, count_in;

   logic                                      is_delim;
   logic [cobsdec_pkg::ByteWidth-1:0]         code_left;
   logic                                      code_long;
   phase_type                                 code_phase;
   logic [cobsdec_pkg::ByteWidth-1:0]         run_dec;
   logic [cobsdec_pkg::CountWidth-1:0]        count_inc;
   logic [cobsdec_pkg::FrameLenWidth-1:0]     length_sat;

   assign is_delim  = (in_byte == delimiter);

   // code byte set-up, a code of zero reads as an empty run
   assign code_left  = (in_byte == '0) ? '0 : in_byte - 1'b1;
   assign code_long  = (in_byte == cobsdec_pkg::LongCode);
   assign code_phase = (code_left == '0) ? PHASE_STUFF : PHASE_RUN;

   assign run_dec   = (run_left_ff == '0) ? '0 : run_left_ff - 1'b1;
   assign count_inc = (count_ff < CountMax) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      if (32'(count_ff) > 32'(LenMax)) begin
         length_sat = LenMax;
      end else begin
         length_sat = cobsdec_pkg::FrameLenWidth'(count_ff);
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      run_left_in = run_left_ff;
      long_run_in = long_run_ff;
      count_in    = count_ff;
      result      = '0;
      unique case (phase_ff)
         PHASE_HUNT: begin
            result.hunting = 1'b1;
            if (is_delim) begin
               phase_in = PHASE_CODE;
            end
         end
         PHASE_CODE: begin
            if (is_delim) begin
               result.frame_done   = 1'b1;
               result.frame_length = length_sat;
               count_in            = '0;
            end else begin
               run_left_in = code_left;
               long_run_in = code_long;
               phase_in    = code_phase;
            end
         end
         PHASE_RUN: begin
            result.data_valid = 1'b1;
            result.data_byte  = in_byte;
            count_in          = count_inc;
            run_left_in       = run_dec;
            if (run_dec == '0) begin
               phase_in = long_run_ff ? PHASE_CODE : PHASE_STUFF;
            end
         end
         PHASE_STUFF: begin
            if (is_delim) begin
               result.frame_done   = 1'b1;
               result.frame_length = length_sat;
               count_in            = '0;
               phase_in            = PHASE_CODE;
            end else begin
               result.data_valid = 1'b1;
               result.data_byte  = delimiter;
               count_in          = count_inc;
               run_left_in       = code_left;
               long_run_in       = code_long;
               phase_in          = code_phase;
            end
         end
         default: begin
            phase_in = PHASE_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HUNT;
         run_left_ff <= '0;
         long_run_ff <= 1'b1;
         count_ff    <= '0;
      end else if (byte_accept) begin
         phase_ff    <= phase_in;
         run_left_ff <= run_left_in;
         long_run_ff <= long_run_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cobsdec_out_stage.sv =====
// cobsdec_out_stage: result register with valid/ready towards the receiver
// depends on cobsdec_pkg
`default_nettype none

module cobsdec_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire cobsdec_pkg::result_type in_result,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output cobsdec_pkg::result_type      out_result
);

   logic                    valid_ff, valid_in;
   cobsdec_pkg::result_type result_ff;
   logic                    load;

   // free slot, or the held result leaves in this cycle
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cobs_stream_frame_decoder.sv =====
// cobs_stream_frame_decoder: top level of the byte-wide cobs deframer
// depends on cobsdec_pkg, cobsdec_core and cobsdec_out_stage
//
// usage
//   req channel: one encoded link byte per transaction (req_in_byte)
//   rsp channel: exactly one result transaction per request transaction,
//     in order: decoded byte (data_valid/data_byte), end of frame with its
//     saturating length (frame_done/frame_length), and a hunting flag for
//     bytes taken before and including the first delimiter
//   csr port: csr_wr_en writes csr_wr_data into the delimiter register at
//     once; write it only while no transaction is in flight
// latency: a result appears on rsp one cycle after its byte is taken
// throughput: one byte per cycle; the decode is a few compares and a
//   decrement between the decode state and the result register
// stall: req_ready stays high while the result register is empty or is
//   being emptied; a stalled receiver holds one result and backs up req
// reset: synchronous, active high; clears the result register, puts the
//   decoder back into the hunt for a delimiter and sets the delimiter to zero
`default_nettype none

module cobs_stream_frame_decoder (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // encoded byte transactions
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic [cobsdec_pkg::ByteWidth-1:0]        req_in_byte,
   // decoded result transactions
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic                                          rsp_data_valid,
   output logic [cobsdec_pkg::ByteWidth-1:0]             rsp_data_byte,
   output logic                                          rsp_frame_done,
   output logic [cobsdec_pkg::FrameLenWidth-1:0]         rsp_frame_length,
   output logic                                          rsp_hunting,
   // delimiter register write
   input  wire logic                                     csr_wr_en,
   input  wire logic [cobsdec_pkg::ByteWidth-1:0]        csr_wr_data
);

   logic [cobsdec_pkg::ByteWidth-1:0] delimiter_ff, delimiter_in;
   logic                              byte_accept;
   cobsdec_pkg::result_type           core_result;
   cobsdec_pkg::result_type           rsp_result;

   // delimiter register, no read-back
   assign delimiter_in = csr_wr_en ? csr_wr_data : delimiter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= '0;
      end else begin
         delimiter_ff <= delimiter_in;
      end
   end

   // decode state moves only when a byte transaction completes
   assign byte_accept = req_valid && req_ready;

   cobsdec_core u_core (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .in_byte     (req_in_byte),
      .delimiter   (delimiter_ff),
      .result      (core_result)
   );

   // result register parts the two channels
   cobsdec_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_result  (core_result),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   assign rsp_data_valid   = rsp_result.data_valid;
   assign rsp_data_byte    = rsp_result.data_byte;
   assign rsp_frame_done   = rsp_result.frame_done;
   assign rsp_frame_length = rsp_result.frame_length;
   assign rsp_hunting      = rsp_result.hunting;

endmodule

`default_nettype wire
